/* design/vnh_pkg.sv */
// ----------------------------------------------------------------------------
// vnh_pkg
// Shared constants, types and tables for the value noise height generator:
// lattice spacing, hash terms, divider reciprocals, pipeline stage numbers
// and the cosine blend weight table.
// ----------------------------------------------------------------------------
package vnh_pkg;

  // Field widths
  localparam int POS_W      = 32;
  localparam int SEED_W     = 32;
  localparam int HEIGHT_W   = 11;
  localparam int HEIGHT_MAX = 2047;

  // Lattice spacing: fine octave CHUNK, coarse octave CHUNK squared
  localparam int CHUNK_LOG2  = 4;
  localparam int CHUNK       = 1 << CHUNK_LOG2;
  localparam int COARSE_LOG2 = 2 * CHUNK_LOG2;

  // Hash range and per-octave divisor
  localparam int HASH_MAX = 400 * 2 + 388 * 3;
  localparam int H_W      = $clog2(HASH_MAX + 1);
  localparam int DIVISOR  = ((HASH_MAX / CHUNK) > 0) ? (HASH_MAX / CHUNK) : 1;

  // Lattice value divider: num = h * scale, lat = num / DIVISOR
  localparam int NUM_W       = H_W + CHUNK_LOG2;
  localparam int DIV_K       = NUM_W;
  localparam int DIV_RECIP   = (1 << DIV_K) / DIVISOR;
  localparam int DIV_RECIP_W = $clog2(DIV_RECIP + 1);
  localparam int DIV_PROD_W  = NUM_W + DIV_RECIP_W;
  localparam int LAT_W       = $clog2(HASH_MAX * CHUNK / DIVISOR + 1);

  // Blend weight in unsigned Q0.16, one extra bit for the value 1.0
  localparam int MU_W     = 17;
  localparam int T_W      = 16;
  localparam int REM_W    = 11;
  localparam int DIF_W    = 12;
  localparam int FRAC_ONE = 1 << 16;
  localparam int BL_W     = LAT_W + MU_W;
  localparam int SUM_W    = ((LAT_W + 1) > (HEIGHT_W + 1)) ? (LAT_W + 1) : (HEIGHT_W + 1);

  // Hash terms: floored residue of (v * mul) modulo m, weighted 2, 3 and -10
  localparam int NTERM   = 3;
  localparam int TERM_P  = 0;
  localparam int TERM_Q  = 1;
  localparam int TERM_R  = 2;
  localparam int WEIGHT_P = 2;
  localparam int WEIGHT_Q = 3;
  localparam int WEIGHT_R = 10;
  localparam int FOLD_W  = 20;
  localparam int MOD_K   = FOLD_W;
  localparam int RES_W   = 9;
  localparam int SUM_H_W = H_W + 2;

  localparam longint unsigned P_MUL = 653;
  localparam longint unsigned P_MOD = 401;
  localparam longint unsigned Q_MUL = 509;
  localparam longint unsigned Q_MOD = 389;
  localparam longint unsigned R_MUL = 11;
  localparam longint unsigned R_MOD = 97;

  localparam longint unsigned P_W1    = (64'd1 << 8) % P_MOD;
  localparam longint unsigned P_W2    = (64'd1 << 16) % P_MOD;
  localparam longint unsigned P_W3    = (64'd1 << 24) % P_MOD;
  localparam longint unsigned P_WRAP  = (P_MOD - ((64'd1 << 32) % P_MOD)) % P_MOD;
  localparam longint unsigned P_RECIP = (64'd1 << MOD_K) / P_MOD;
  localparam longint unsigned Q_W1    = (64'd1 << 8) % Q_MOD;
  localparam longint unsigned Q_W2    = (64'd1 << 16) % Q_MOD;
  localparam longint unsigned Q_W3    = (64'd1 << 24) % Q_MOD;
  localparam longint unsigned Q_WRAP  = (Q_MOD - ((64'd1 << 32) % Q_MOD)) % Q_MOD;
  localparam longint unsigned Q_RECIP = (64'd1 << MOD_K) / Q_MOD;
  localparam longint unsigned R_W1    = (64'd1 << 8) % R_MOD;
  localparam longint unsigned R_W2    = (64'd1 << 16) % R_MOD;
  localparam longint unsigned R_W3    = (64'd1 << 24) % R_MOD;
  localparam longint unsigned R_WRAP  = (R_MOD - ((64'd1 << 32) % R_MOD)) % R_MOD;
  localparam longint unsigned R_RECIP = (64'd1 << MOD_K) / R_MOD;

  // Pipeline stage numbers; a register closes each stage
  localparam int ST_INDEX = 1;   // seed plus lattice index, fractions
  localparam int ST_PROD  = 2;   // hash products, weight table lookup
  localparam int ST_FOLD  = 3;   // byte fold of products, weight interpolation
  localparam int ST_EST   = 4;   // residue quotient estimate
  localparam int ST_RES   = 5;   // corrected residues
  localparam int ST_HASH  = 6;   // combined hash value
  localparam int ST_DEST  = 7;   // lattice value quotient estimate
  localparam int ST_LAT   = 8;   // corrected lattice values
  localparam int ST_MUL   = 9;   // blend products
  localparam int ST_OUT   = 10;  // summed and saturated height
  localparam int NSTG     = ST_OUT;

  typedef logic [NSTG:1] stage_en_t;

  typedef struct packed {
    logic [31:0] mul;
    logic [31:0] modulus;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [31:0] wrap;
    logic [31:0] recip;
  } term_const_t;

  function automatic term_const_t term_const(input logic [1:0] k);
    term_const_t c;
    unique case (k)
      2'(TERM_P): c = '{32'(P_MUL), 32'(P_MOD), 32'(P_W1), 32'(P_W2), 32'(P_W3),
                        32'(P_WRAP), 32'(P_RECIP)};
      2'(TERM_Q): c = '{32'(Q_MUL), 32'(Q_MOD), 32'(Q_W1), 32'(Q_W2), 32'(Q_W3),
                        32'(Q_WRAP), 32'(Q_RECIP)};
      2'(TERM_R): c = '{32'(R_MUL), 32'(R_MOD), 32'(R_W1), 32'(R_W2), 32'(R_W3),
                        32'(R_WRAP), 32'(R_RECIP)};
      default:    c = '0;
    endcase
    return c;
  endfunction

  // sin^2(pi*i/64) in Q0.16, sampled at t = i/32
  function automatic logic [MU_W-1:0] mu_rom(input logic [5:0] i);
    logic [MU_W-1:0] m;
    unique case (i)
      6'd0:  m = 17'd0;     6'd1:  m = 17'd158;   6'd2:  m = 17'd630;
      6'd3:  m = 17'd1411;  6'd4:  m = 17'd2494;  6'd5:  m = 17'd3869;
      6'd6:  m = 17'd5522;  6'd7:  m = 17'd7438;  6'd8:  m = 17'd9598;
      6'd9:  m = 17'd11980; 6'd10: m = 17'd14563; 6'd11: m = 17'd17321;
      6'd12: m = 17'd20228; 6'd13: m = 17'd23256; 6'd14: m = 17'd26375;
      6'd15: m = 17'd29556; 6'd16: m = 17'd32768; 6'd17: m = 17'd35980;
      6'd18: m = 17'd39161; 6'd19: m = 17'd42280; 6'd20: m = 17'd45308;
      6'd21: m = 17'd48215; 6'd22: m = 17'd50973; 6'd23: m = 17'd53556;
      6'd24: m = 17'd55938; 6'd25: m = 17'd58098; 6'd26: m = 17'd60014;
      6'd27: m = 17'd61667; 6'd28: m = 17'd63042; 6'd29: m = 17'd64125;
      6'd30: m = 17'd64906; 6'd31: m = 17'd65378; 6'd32: m = 17'd65536;
      default: m = 17'd0;
    endcase
    return m;
  endfunction

endpackage

/* design/vnh_if.sv */
// ----------------------------------------------------------------------------
// vnh_if
// Valid/ready stream interfaces for positions into and heights out of the
// value noise height generator.
// ----------------------------------------------------------------------------
interface vnh_pos_if import vnh_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] position;

  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface

interface vnh_height_if import vnh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] height;

  modport source (output valid, output height, input ready);
  modport sink   (input valid, input height, output ready);
endinterface

/* design/vnh_hash.sv */
// ----------------------------------------------------------------------------
// vnh_hash
// Lattice hash pipeline for one seeded lattice index: three wrapping products,
// floored residues by constant reciprocal, weighted sum and absolute value.
// ----------------------------------------------------------------------------
module vnh_hash import vnh_pkg::*; (
  input  logic               clk,
  input  stage_en_t          en,
  input  logic [SEED_W-1:0]  v,
  output logic [H_W-1:0]     h
);

  logic [RES_W-1:0] res [NTERM];

  genvar t;
  generate
    for (t = 0; t < NTERM; t++) begin : g_term
      localparam term_const_t TC = term_const(2'(t));

      logic [31:0]         prod;
      logic [FOLD_W-1:0]   fold;
      logic [FOLD_W-1:0]   fold_next;
      logic [FOLD_W-1:0]   fold_d;
      logic [FOLD_W-1:0]   est;
      logic [2*FOLD_W-1:0] est_prod;
      logic [FOLD_W-1:0]   diff;

      // Fold the four bytes by their weights modulo m, add the sign wrap
      always_comb begin
        fold_next = FOLD_W'(prod[7:0])
                  + FOLD_W'(prod[15:8])  * FOLD_W'(TC.w1)
                  + FOLD_W'(prod[23:16]) * FOLD_W'(TC.w2)
                  + FOLD_W'(prod[31:24]) * FOLD_W'(TC.w3)
                  + (prod[31] ? FOLD_W'(TC.wrap) : FOLD_W'(0));
      end

      assign est_prod = (2*FOLD_W)'(fold) * (2*FOLD_W)'(TC.recip);

      // Remainder from the estimate, one below the true quotient at worst
      assign diff = fold_d - FOLD_W'(est * FOLD_W'(TC.modulus));

      always_ff @(posedge clk) begin
        if (en[ST_PROD]) begin
          prod <= v * TC.mul;
        end
        if (en[ST_FOLD]) begin
          fold <= fold_next;
        end
        if (en[ST_EST]) begin
          fold_d <= fold;
          est    <= est_prod[2*FOLD_W-1:FOLD_W];
        end
        if (en[ST_RES]) begin
          if (diff >= FOLD_W'(TC.modulus)) begin
            res[t] <= RES_W'(diff - FOLD_W'(TC.modulus));
          end else begin
            res[t] <= RES_W'(diff);
          end
        end
      end
    end
  endgenerate

  // Combine the residues and take the magnitude
  logic [SUM_H_W-1:0]        pos_part;
  logic [SUM_H_W-1:0]        neg_part;
  logic signed [SUM_H_W-1:0] s;

  always_comb begin
    pos_part = SUM_H_W'(res[TERM_P]) * SUM_H_W'(WEIGHT_P)
             + SUM_H_W'(res[TERM_Q]) * SUM_H_W'(WEIGHT_Q);
    neg_part = SUM_H_W'(res[TERM_R]) * SUM_H_W'(WEIGHT_R);
    s        = signed'(pos_part - neg_part);
  end

  always_ff @(posedge clk) begin
    if (en[ST_HASH]) begin
      h <= (s < 0) ? H_W'(-s) : H_W'(s);
    end
  end

endmodule

/* design/vnh_weight.sv */
// ----------------------------------------------------------------------------
// vnh_weight
// Cosine blend weights for both octaves: table lookup, linear interpolation
// between table entries, then a delay line to meet the lattice values.
// ----------------------------------------------------------------------------
module vnh_weight import vnh_pkg::*; (
  input  logic                   clk,
  input  stage_en_t              en,
  input  logic [COARSE_LOG2-1:0] frac_c,
  input  logic [CHUNK_LOG2-1:0]  frac_f,
  output logic [MU_W-1:0]        mu [2]
);

  logic [T_W-1:0]   t   [2];
  logic [MU_W-1:0]  lo  [2];
  logic [DIF_W-1:0] dif [2];
  logic [REM_W-1:0] rem [2];
  logic [MU_W-1:0]  mu_d [2][ST_FOLD:ST_LAT];

  // Fraction to Q0.16 position within the lattice cell
  assign t[0] = T_W'(frac_c) << (T_W - COARSE_LOG2);
  assign t[1] = T_W'(frac_f) << (T_W - CHUNK_LOG2);

  genvar o;
  generate
    for (o = 0; o < 2; o++) begin : g_oct
      logic [5:0]          idx;
      logic [MU_W-1:0]     hi_v;
      logic [MU_W-1:0]     lo_v;
      logic [DIF_W+REM_W-1:0] step;

      assign idx  = {1'b0, t[o][T_W-1:REM_W]};
      assign lo_v = mu_rom(idx);
      assign hi_v = mu_rom(idx + 6'd1);
      assign step = (DIF_W+REM_W)'(dif[o]) * (DIF_W+REM_W)'(rem[o]);

      always_ff @(posedge clk) begin
        // Look up the neighbouring table entries
        if (en[ST_PROD]) begin
          lo[o]  <= lo_v;
          dif[o] <= DIF_W'(hi_v - lo_v);
          rem[o] <= t[o][REM_W-1:0];
        end
        // Interpolate, truncating
        if (en[ST_FOLD]) begin
          mu_d[o][ST_FOLD] <= lo[o] + MU_W'(step >> REM_W);
        end
        // Hold the weight alongside the hash pipeline
        for (int k = ST_FOLD + 1; k <= ST_LAT; k++) begin
          if (en[k]) begin
            mu_d[o][k] <= mu_d[o][k-1];
          end
        end
      end

      assign mu[o] = mu_d[o][ST_LAT];
    end
  endgenerate

endmodule

/* design/vnh_blend.sv */
// ----------------------------------------------------------------------------
// vnh_blend
// Scales and divides the four hash values into lattice values, blends each
// octave with its weight, adds the octaves and saturates the height.
// ----------------------------------------------------------------------------
module vnh_blend import vnh_pkg::*; (
  input  logic                clk,
  input  stage_en_t           en,
  input  logic [H_W-1:0]      h  [4],
  input  logic [MU_W-1:0]     mu [2],
  output logic [HEIGHT_W-1:0] height
);

  logic [NUM_W-1:0]  num [4];
  logic [LAT_W-1:0]  est [4];
  logic [LAT_W-1:0]  lat [4];
  logic [BL_W-1:0]   pa  [2];
  logic [BL_W-1:0]   pb  [2];

  genvar k;
  generate
    for (k = 0; k < 4; k++) begin : g_lat
      logic [NUM_W-1:0]      num_next;
      logic [DIV_PROD_W-1:0] prod;
      logic [NUM_W-1:0]      diff;

      // Coarse octave values are scaled by CHUNK before the divide
      assign num_next = (k < 2) ? (NUM_W'(h[k]) << CHUNK_LOG2) : NUM_W'(h[k]);
      assign prod     = DIV_PROD_W'(num_next) * DIV_PROD_W'(DIV_RECIP);
      assign diff     = num[k] - NUM_W'(NUM_W'(est[k]) * NUM_W'(DIVISOR));

      always_ff @(posedge clk) begin
        if (en[ST_DEST]) begin
          num[k] <= num_next;
          est[k] <= LAT_W'(prod >> DIV_K);
        end
        if (en[ST_LAT]) begin
          if (diff >= NUM_W'(DIVISOR)) begin
            lat[k] <= est[k] + LAT_W'(1);
          end else begin
            lat[k] <= est[k];
          end
        end
      end
    end
  endgenerate

  // Blend products for each octave
  genvar o;
  generate
    for (o = 0; o < 2; o++) begin : g_oct
      always_ff @(posedge clk) begin
        if (en[ST_MUL]) begin
          pa[o] <= BL_W'(MU_W'(FRAC_ONE) - mu[o]) * BL_W'(lat[2*o]);
          pb[o] <= BL_W'(mu[o]) * BL_W'(lat[2*o+1]);
        end
      end
    end
  endgenerate

  // Sum the octaves and saturate
  logic [LAT_W-1:0] oct [2];
  logic [SUM_W-1:0] total;

  always_comb begin
    oct[0] = LAT_W'((pa[0] + pb[0]) >> 16);
    oct[1] = LAT_W'((pa[1] + pb[1]) >> 16);
    total  = SUM_W'(oct[0]) + SUM_W'(oct[1]);
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      if (total > SUM_W'(HEIGHT_MAX)) begin
        height <= HEIGHT_W'(HEIGHT_MAX);
      end else begin
        height <= HEIGHT_W'(total);
      end
    end
  end

endmodule

/* design/value_noise_height_generator.sv */
// ----------------------------------------------------------------------------
// value_noise_height_generator
// Terrain height from two octaves of 1D value noise with cosine blending.
//
//   Channel     Dir   Payload                      Transaction
//   positions   in    position  (32 bit signed)    valid && ready
//   heights     out   height    (11 bit unsigned)  valid && ready
//   cfg         in    cfg_data  (noise seed)       cfg_write high
//
// One position per cycle is taken while the heights output is not stalled;
// each height passes through the ten register stages of the hash and divide pipeline.
// Reset clears every stage valid bit and sets the seed to zero.
// A stage holds while it is full and the stage after it is stalled; empty
// stages keep filling, so bubbles close up and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module value_noise_height_generator import vnh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [SEED_W-1:0] cfg_data,
  vnh_pos_if.sink           positions,
  vnh_height_if.source      heights
);

  logic [SEED_W-1:0]      noise_seed;
  logic [NSTG:1]          v;
  logic [NSTG-1:0]        v_in;
  stage_en_t              en;

  logic [SEED_W-1:0]      idx_c;
  logic [SEED_W-1:0]      idx_f;
  logic [SEED_W-1:0]      hv [4];
  logic [COARSE_LOG2-1:0] frac_c;
  logic [CHUNK_LOG2-1:0]  frac_f;
  logic [H_W-1:0]         h  [4];
  logic [MU_W-1:0]        mu [2];

  // Seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_seed <= '0;
    end else if (cfg_write) begin
      noise_seed <= cfg_data;
    end
  end

  // Stage enables: advance when empty or when the next stage advances
  assign en[NSTG] = !v[NSTG] || heights.ready;
  genvar k;
  generate
    for (k = 1; k < NSTG; k++) begin : g_en
      assign en[k] = !v[k] || en[k+1];
    end
  endgenerate

  // Valid bits travel with the data
  assign v_in = {v[NSTG-1:1], positions.valid};
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 1; s <= NSTG; s++) begin
        if (en[s]) begin
          v[s] <= v_in[s-1];
        end
      end
    end
  end

  assign positions.ready = en[ST_INDEX];
  assign heights.valid   = v[NSTG];

  // Floored lattice indices by arithmetic shift
  assign idx_c = SEED_W'(unsigned'(positions.position >>> COARSE_LOG2));
  assign idx_f = SEED_W'(unsigned'(positions.position >>> CHUNK_LOG2));

  // Seeded indices of both lattice neighbours, and cell fractions
  always_ff @(posedge clk) begin
    if (en[ST_INDEX]) begin
      hv[0]  <= noise_seed + idx_c;
      hv[1]  <= noise_seed + idx_c + SEED_W'(1);
      hv[2]  <= noise_seed + idx_f;
      hv[3]  <= noise_seed + idx_f + SEED_W'(1);
      frac_c <= positions.position[COARSE_LOG2-1:0];
      frac_f <= positions.position[CHUNK_LOG2-1:0];
    end
  end

  generate
    for (k = 0; k < 4; k++) begin : g_hash
      vnh_hash u_hash (
        .clk (clk),
        .en  (en),
        .v   (hv[k]),
        .h   (h[k])
      );
    end
  endgenerate

  vnh_weight u_weight (
    .clk    (clk),
    .en     (en),
    .frac_c (frac_c),
    .frac_f (frac_f),
    .mu     (mu)
  );

  vnh_blend u_blend (
    .clk    (clk),
    .en     (en),
    .h      (h),
    .mu     (mu),
    .height (heights.height)
  );

endmodule

/* design/vnh_checker.sv */
// ----------------------------------------------------------------------------
// vnh_checker
// Port-level checks on the value noise height generator: output holding
// under stall, empty pipeline after reset, and transaction accounting.
// ----------------------------------------------------------------------------
module vnh_checker import vnh_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                pos_valid,
  input logic                pos_ready,
  input logic                height_valid,
  input logic                height_ready,
  input logic [HEIGHT_W-1:0] height
);

  localparam int CNT_W = $clog2(NSTG + 1) + 1;

  logic             in_acc;
  logic             out_acc;
  logic [CNT_W-1:0] outstanding;

  assign in_acc  = pos_valid && pos_ready;
  assign out_acc = height_valid && height_ready;

  // Track transactions taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_acc && !out_acc) begin
      outstanding <= outstanding + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      outstanding <= outstanding - CNT_W'(1);
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    height_valid && !height_ready |=> height_valid)
    else $error("height valid dropped while stalled");

  a_hold_height: assert property (@(posedge clk) disable iff (rst)
    height_valid && !height_ready |=> $stable(height))
    else $error("height changed while stalled");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !height_valid)
    else $error("height offered straight after reset");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !height_valid |-> pos_ready)
    else $error("input stalled with output stage empty");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    height_valid |-> (outstanding != '0) && (outstanding <= CNT_W'(NSTG)))
    else $error("height offered without a matching position");

endmodule

bind value_noise_height_generator vnh_checker u_vnh_checker (
  .clk          (clk),
  .rst          (rst),
  .pos_valid    (positions.valid),
  .pos_ready    (positions.ready),
  .height_valid (heights.valid),
  .height_ready (heights.ready),
  .height       (heights.height)
);
